// File: sv/zhp_pkg.sv
package zhp_pkg;

   localparam int unsigned CEN_FIXED   = 42;
   localparam int unsigned LOC_FIXED   = 26;
   localparam int unsigned SIG_BYTES   = 4;
   localparam int unsigned FRAME_BITS  = 8 * CEN_FIXED;
   localparam int unsigned SHIFT_BITS  = FRAME_BITS - 8;
   // local header bytes land this many bytes higher in the frame than central ones
   localparam int unsigned LOC_SHIFT   = (CEN_FIXED - LOC_FIXED) - 2;

   localparam logic [31:0] CEN_SIG = 32'h504B_0102;
   localparam logic [31:0] LOC_SIG = 32'h504B_0304;
   localparam logic [7:0]  BYTE_MASK = 8'hFF;

   // central record byte offsets, after the signature
   localparam int unsigned OFS_GP_FLAGS  = 4;
   localparam int unsigned OFS_METHOD    = 6;
   localparam int unsigned OFS_TIME_DATE = 8;
   localparam int unsigned OFS_CRC       = 12;
   localparam int unsigned OFS_CSIZE     = 16;
   localparam int unsigned OFS_USIZE     = 20;
   localparam int unsigned OFS_NAME_LEN  = 24;
   localparam int unsigned OFS_EXTRA_LEN = 26;
   localparam int unsigned OFS_COMM_LEN  = 28;
   localparam int unsigned OFS_HDR_OFS   = 38;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_KIND  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_LIMIT = 1'd1;

   localparam logic KIND_CENTRAL = 1'b0;
   localparam logic KIND_LOCAL   = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_SIG = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_CSIG  = 6'b000010,
      PH_CFIX  = 6'b000100,
      PH_CSKIP = 6'b001000,
      PH_LHUNT = 6'b010000,
      PH_LFIX  = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      FRAME_CENTRAL = 2'd0,
      FRAME_LOCAL   = 2'd1,
      FRAME_BAD_SIG = 2'd2
   } frame_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [15:0] record_index;
      logic [15:0] gp_flags;
      logic [15:0] method;
      logic [31:0] dos_time_date;
      logic [31:0] crc_value;
      logic [31:0] compressed_size;
      logic [31:0] uncompressed_size;
      logic [15:0] name_length;
      logic [15:0] extra_length;
      logic [15:0] comment_length;
      logic [31:0] header_offset;
   } rsp_type;

   // raw header bytes, byte k of the frame at bits [8k+7:8k]
   typedef struct packed {
      frame_kind_type          kind;
      logic [15:0]             record_index;
      logic [FRAME_BITS-1:0]   bytes;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } push_type;

endpackage

// File: sv/zhp_front.sv
module zhp_front import zhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic        header_kind,
   input  logic [15:0] record_limit,
   output push_type    push
);

   phase_type             phase_ff, phase_in;
   logic [31:0]           window_ff, window_in;
   logic [5:0]            count_ff, count_in;
   logic [SHIFT_BITS-1:0] shift_ff, shift_in;
   logic [17:0]           skip_ff, skip_in;
   logic [15:0]           done_ff, done_in;
   logic                  emit;
   frame_kind_type        emit_kind;
   logic [15:0]           emit_index;
   logic [7:0]            byte_val;

   assign byte_val = req_data.data_byte & BYTE_MASK;

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      skip_in    = skip_ff;
      done_in    = done_ff;
      emit       = 1'b0;
      emit_kind  = FRAME_CENTRAL;
      emit_index = done_ff;

      if (req_data.first_byte) begin
         done_in   = '0;
         count_in  = '0;
         skip_in   = '0;
         window_in = '0;
         if (header_kind == KIND_LOCAL) begin
            phase_in = PH_LHUNT;
         end else if (record_limit == 16'd0) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_CSIG;
         end
      end

      case (phase_in)
         PH_CSIG: begin
            window_in = {window_in[23:0], byte_val};
            if (count_in == 6'(SIG_BYTES - 1)) begin
               count_in = '0;
               if (window_in == CEN_SIG) begin
                  phase_in = PH_CFIX;
               end else begin
                  emit       = 1'b1;
                  emit_kind  = FRAME_BAD_SIG;
                  emit_index = '0;
                  done_in    = done_in + 16'd1;
                  if (done_in >= record_limit) begin
                     phase_in = PH_IDLE;
                  end
               end
            end else begin
               count_in = count_in + 6'd1;
            end
         end
         PH_CFIX: begin
            shift_in = {byte_val, shift_ff[SHIFT_BITS-1:8]};
            if (count_in == 6'(CEN_FIXED - 1)) begin
               count_in   = '0;
               window_in  = '0;
               emit       = 1'b1;
               emit_kind  = FRAME_CENTRAL;
               emit_index = done_in;
               skip_in    = 18'(shift_ff[8*OFS_NAME_LEN +: 16])
                          + 18'(shift_ff[8*OFS_EXTRA_LEN +: 16])
                          + 18'(shift_ff[8*OFS_COMM_LEN +: 16]);
               phase_in   = (skip_in != 18'd0) ? PH_CSKIP : PH_CSIG;
               done_in    = done_in + 16'd1;
               if (done_in >= record_limit) begin
                  phase_in = PH_IDLE;
               end
            end else begin
               count_in = count_in + 6'd1;
            end
         end
         PH_CSKIP: begin
            if (skip_in != 18'd0) begin
               skip_in = skip_in - 18'd1;
            end
            if (skip_in == 18'd0) begin
               phase_in = PH_CSIG;
            end
         end
         PH_LHUNT: begin
            window_in = {window_in[23:0], byte_val};
            if (window_in == LOC_SIG) begin
               phase_in = PH_LFIX;
               count_in = '0;
            end
         end
         PH_LFIX: begin
            shift_in = {byte_val, shift_ff[SHIFT_BITS-1:8]};
            if (count_in == 6'(LOC_FIXED - 1)) begin
               count_in   = '0;
               phase_in   = PH_IDLE;
               emit       = 1'b1;
               emit_kind  = FRAME_LOCAL;
               emit_index = '0;
            end else begin
               count_in = count_in + 6'd1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         window_ff <= '0;
         count_ff  <= '0;
         skip_ff   <= '0;
         done_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         count_ff  <= count_in;
         skip_ff   <= skip_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         shift_ff <= shift_in;
      end
   end

   // frame is the current byte on top of the 41 shifted ones
   assign push.valid              = accept & emit;
   assign push.frame.kind         = emit_kind;
   assign push.frame.record_index = emit_index;
   assign push.frame.bytes        = {byte_val, shift_ff};

endmodule

// File: sv/zhp_queue.sv
module zhp_queue import zhp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output frame_type head
);

   frame_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      count_in = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

// File: sv/zhp_back.sv
module zhp_back import zhp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  frame_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic                  out_valid_ff;
   rsp_type               out_data_ff, out_data_in;
   logic [FRAME_BITS-1:0] view;

   // local header fields sit LOC_SHIFT bytes above their central positions
   assign view = (head.kind == FRAME_LOCAL) ? (head.bytes >> (8 * LOC_SHIFT)) : head.bytes;

   always_comb begin
      out_data_in = '0;
      case (head.kind)
         FRAME_CENTRAL, FRAME_LOCAL: begin
            out_data_in.status            = STATUS_OK;
            out_data_in.record_index      = head.record_index;
            out_data_in.gp_flags          = view[8*OFS_GP_FLAGS +: 16];
            out_data_in.method            = view[8*OFS_METHOD +: 16];
            out_data_in.dos_time_date     = view[8*OFS_TIME_DATE +: 32];
            out_data_in.crc_value         = view[8*OFS_CRC +: 32];
            out_data_in.compressed_size   = view[8*OFS_CSIZE +: 32];
            out_data_in.uncompressed_size = view[8*OFS_USIZE +: 32];
            out_data_in.name_length       = view[8*OFS_NAME_LEN +: 16];
            out_data_in.extra_length      = view[8*OFS_EXTRA_LEN +: 16];
            if (head.kind == FRAME_CENTRAL) begin
               out_data_in.comment_length = view[8*OFS_COMM_LEN +: 16];
               out_data_in.header_offset  = view[8*OFS_HDR_OFS +: 32];
            end
         end
         FRAME_BAD_SIG: begin
            out_data_in.status = STATUS_BAD_SIG;
         end
         default: begin
            out_data_in = '0;
         end
      endcase
   end

   assign pop = head_valid & (~out_valid_ff | ~rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: sv/zip_header_field_parser.sv
// ZIP header field parser. Takes one archive byte per cycle; a byte with
// first_byte set restarts parsing in the mode set by header_kind (central
// directory records, or a hunt for one local file header). Most bytes only
// shift into the header register or count down the name/extra/comment skip;
// the byte that completes a header (or a bad central signature) produces one
// transaction on rsp via the queue and output register. Completed headers
// wait in a two-entry queue ahead of the output register, so req_stall only
// rises when that queue is full, i.e. when the consumer has held off rsp.
// Sustained rate is one byte per cycle. header_kind and record_limit are
// written through csr; header_kind is used at the next restart.
module zip_header_field_parser import zhp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic        header_kind_ff;
   logic [15:0] record_limit_ff;
   logic        accept;
   logic        q_full;
   logic        q_not_empty;
   logic        q_pop;
   frame_type   q_head;
   push_type    push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_kind_ff  <= KIND_CENTRAL;
         record_limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEADER_KIND:  header_kind_ff  <= csr_wdata[0];
            CSR_RECORD_LIMIT: record_limit_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   zhp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .header_kind  (header_kind_ff),
      .record_limit (record_limit_ff),
      .push         (push)
   );

   zhp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   zhp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_not_empty),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// File: dv/zip_header_checker.sv
`timescale 1ns / 1ps

module zip_header_checker import zhp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            outstanding,
   output int unsigned            mismatches
);

   // shadow of the register file
   logic        kind_cfg;
   logic [15:0] limit_cfg;

   // shadow of the parser
   phase_type   phase;
   logic [31:0] sig_window;
   int unsigned field_count;
   logic [7:0]  hdr_bytes [CEN_FIXED];
   logic [17:0] skip_left;
   logic [15:0] rec_count;

   rsp_type     expected_headers [$];
   rsp_type     want;

   initial mismatches = 0;

   function automatic logic [31:0] le_bytes(input int unsigned ofs, input int unsigned n);
      logic [31:0] v;
      v = '0;
      for (int unsigned i = 0; i < n; i++) begin
         v |= 32'(hdr_bytes[ofs + i]) << (8 * i);
      end
      return v;
   endfunction

   // shift is 2 in local mode: the local header has no version-made-by field
   function automatic rsp_type header_fields(input int unsigned shift);
      rsp_type h;
      h = '0;
      h.status            = STATUS_OK;
      h.gp_flags          = 16'(le_bytes(OFS_GP_FLAGS - shift, 2));
      h.method            = 16'(le_bytes(OFS_METHOD - shift, 2));
      h.dos_time_date     = le_bytes(OFS_TIME_DATE - shift, 4);
      h.crc_value         = le_bytes(OFS_CRC - shift, 4);
      h.compressed_size   = le_bytes(OFS_CSIZE - shift, 4);
      h.uncompressed_size = le_bytes(OFS_USIZE - shift, 4);
      h.name_length       = 16'(le_bytes(OFS_NAME_LEN - shift, 2));
      h.extra_length      = 16'(le_bytes(OFS_EXTRA_LEN - shift, 2));
      return h;
   endfunction

   task automatic count_record();
      rec_count++;
      if (rec_count >= limit_cfg) begin
         phase = PH_IDLE;
      end
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic restart);
      rsp_type h;
      if (restart) begin
         rec_count   = '0;
         field_count = 0;
         skip_left   = '0;
         sig_window  = '0;
         if (kind_cfg == KIND_LOCAL) begin
            phase = PH_LHUNT;
         end else begin
            phase = (limit_cfg == '0) ? PH_IDLE : PH_CSIG;
         end
      end
      case (phase)
         PH_CSIG: begin
            sig_window = {sig_window[23:0], b};
            field_count++;
            if (field_count >= SIG_BYTES) begin
               field_count = 0;
               if (sig_window == CEN_SIG) begin
                  phase = PH_CFIX;
               end else begin
                  h = '0;
                  h.status = STATUS_BAD_SIG;
                  expected_headers.push_back(h);
                  count_record();
               end
            end
         end
         PH_CFIX: begin
            hdr_bytes[field_count] = b;
            field_count++;
            if (field_count >= CEN_FIXED) begin
               field_count = 0;
               sig_window  = '0;
               h = header_fields(0);
               h.record_index   = rec_count;
               h.comment_length = 16'(le_bytes(OFS_COMM_LEN, 2));
               h.header_offset  = le_bytes(OFS_HDR_OFS, 4);
               skip_left = 18'(h.name_length) + 18'(h.extra_length) + 18'(h.comment_length);
               phase = (skip_left != '0) ? PH_CSKIP : PH_CSIG;
               expected_headers.push_back(h);
               count_record();
            end
         end
         PH_CSKIP: begin
            if (skip_left != '0) begin
               skip_left--;
            end
            if (skip_left == '0) begin
               phase = PH_CSIG;
            end
         end
         PH_LHUNT: begin
            sig_window = {sig_window[23:0], b};
            if (sig_window == LOC_SIG) begin
               phase       = PH_LFIX;
               field_count = 0;
            end
         end
         PH_LFIX: begin
            hdr_bytes[field_count] = b;
            field_count++;
            if (field_count >= LOC_FIXED) begin
               field_count = 0;
               phase       = PH_IDLE;
               expected_headers.push_back(header_fields(2));
            end
         end
         default: begin
            phase = PH_IDLE;
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kind_cfg    = KIND_CENTRAL;
         limit_cfg   = '0;
         phase       = PH_IDLE;
         sig_window  = '0;
         field_count = 0;
         skip_left   = '0;
         rec_count   = '0;
         expected_headers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEADER_KIND) begin
               kind_cfg = csr_wdata[0];
            end else begin
               limit_cfg = csr_wdata;
            end
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_data.data_byte, req_data.first_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_headers.size() == 0) begin
               $error("header transaction with nothing expected");
               mismatches++;
            end else begin
               want = expected_headers.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("record_index", 32'(want.record_index), 32'(rsp_data.record_index));
               check_field("gp_flags", 32'(want.gp_flags), 32'(rsp_data.gp_flags));
               check_field("method", 32'(want.method), 32'(rsp_data.method));
               check_field("dos_time_date", want.dos_time_date, rsp_data.dos_time_date);
               check_field("crc_value", want.crc_value, rsp_data.crc_value);
               check_field("compressed_size", want.compressed_size,
                           rsp_data.compressed_size);
               check_field("uncompressed_size", want.uncompressed_size,
                           rsp_data.uncompressed_size);
               check_field("name_length", 32'(want.name_length), 32'(rsp_data.name_length));
               check_field("extra_length", 32'(want.extra_length),
                           32'(rsp_data.extra_length));
               check_field("comment_length", 32'(want.comment_length),
                           32'(rsp_data.comment_length));
               check_field("header_offset", want.header_offset, rsp_data.header_offset);
            end
         end
      end
      outstanding <= expected_headers.size();
   end

endmodule

// File: dv/tb_zip_header_field_parser.sv
`timescale 1ns / 1ps

module tb_zip_header_field_parser;
   import zhp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned sent = 0;
   int unsigned cycle_count = 0;
   int unsigned tx_pct = 0;
   int unsigned rx_pct = 0;

   zip_header_field_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   zip_header_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic restart);
      while ($urandom_range(0, 99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, first_byte: restart};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic send_noise(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // signature goes out first byte first: 'P','K',...
   task automatic send_sig(input logic restart, input logic [31:0] sig);
      push_byte(sig[31:24], restart);
      push_byte(sig[23:16], 1'b0);
      push_byte(sig[15:8], 1'b0);
      push_byte(sig[7:0], 1'b0);
   endtask

   // fill < 0 gives random bytes; the three lengths land in place when nbytes reaches them
   task automatic send_cen_body(input int unsigned nbytes, input int fill,
                                input logic [15:0] nl, input logic [15:0] el,
                                input logic [15:0] cl);
      logic [7:0] b;
      for (int unsigned k = 0; k < nbytes; k++) begin
         b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         case (k)
            OFS_NAME_LEN:      b = nl[7:0];
            OFS_NAME_LEN + 1:  b = nl[15:8];
            OFS_EXTRA_LEN:     b = el[7:0];
            OFS_EXTRA_LEN + 1: b = el[15:8];
            OFS_COMM_LEN:      b = cl[7:0];
            OFS_COMM_LEN + 1:  b = cl[15:8];
            default: ;
         endcase
         push_byte(b, 1'b0);
      end
   endtask

   task automatic send_loc_body(input int unsigned nbytes, input int fill);
      for (int unsigned k = 0; k < nbytes; k++) begin
         push_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill), 1'b0);
      end
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain: stop sending, wait out every expected header plus pipeline latency
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_central(input int unsigned budget);
      int unsigned stop_at;
      int unsigned recs;
      logic [15:0] nl, el, cl;
      logic        good;
      logic        abandon;
      stop_at = sent + budget;
      while (sent < stop_at) begin
         recs    = $urandom_range(1, 6);
         abandon = 1'b0;
         for (int unsigned r = 0; r < recs && !abandon; r++) begin
            good = ($urandom_range(0, 99) >= 20);
            send_sig(r == 0, good ? CEN_SIG : (CEN_SIG ^ ($urandom() | 32'h1)));
            if (good) begin
               nl = 16'($urandom_range(0, 4));
               el = 16'($urandom_range(0, 2));
               cl = 16'($urandom_range(0, 2));
               if ($urandom_range(0, 19) == 0) begin
                  nl = 16'($urandom_range(0, 60));
               end
               if ($urandom_range(0, 19) == 0) begin
                  // cut the record short; the next run restarts over it
                  send_cen_body($urandom_range(0, CEN_FIXED - 1), -1, nl, el, cl);
                  abandon = 1'b1;
               end else begin
                  send_cen_body(CEN_FIXED, -1, nl, el, cl);
                  send_noise(32'(nl) + 32'(el) + 32'(cl));
               end
            end
         end
      end
   endtask

   task automatic random_local(input int unsigned budget);
      int unsigned stop_at;
      stop_at = sent + budget;
      while (sent < stop_at) begin
         if ($urandom_range(0, 1) == 0) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1);
            send_noise($urandom_range(0, 6));
            send_sig(1'b0, LOC_SIG);
         end else begin
            send_sig(1'b1, LOC_SIG);
         end
         if ($urandom_range(0, 19) == 0) begin
            send_loc_body($urandom_range(0, LOC_FIXED - 1), -1);
         end else begin
            send_loc_body(LOC_FIXED, -1);
            send_noise($urandom_range(0, 3));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_pct = 21;
      rx_pct = 46;

      // central mode, limit of three records
      set_reg(CSR_HEADER_KIND, CSR_DATA_W'(KIND_CENTRAL));
      set_reg(CSR_RECORD_LIMIT, 16'd3);
      send_noise(2);                       // no restart yet: ignored
      send_sig(1'b1, CEN_SIG ^ 32'h1);     // bad signature
      send_sig(1'b0, CEN_SIG);
      send_cen_body(CEN_FIXED, 0, 16'h0, 16'h0, 16'h0);
      send_sig(1'b0, CEN_SIG);
      send_cen_body(CEN_FIXED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_noise(3);                       // limit reached: ignored
      send_sig(1'b1, CEN_SIG);
      send_cen_body(CEN_FIXED, 8'hA5, 16'h1, 16'h1, 16'h1);
      send_noise(3);
      send_sig(1'b0, CEN_SIG);
      send_cen_body(20, 8'h5A, 16'h0, 16'h0, 16'h0);
      send_sig(1'b1, CEN_SIG);             // restart inside a record
      send_cen_body(CEN_FIXED, -1, 16'h100, 16'h0, 16'h0);
      send_noise(10);
      send_sig(1'b1, CEN_SIG);             // restart inside the skip
      send_cen_body(CEN_FIXED, -1, 16'h0, 16'h0, 16'h0);
      settle();

      set_reg(CSR_RECORD_LIMIT, 16'd0);
      send_sig(1'b1, CEN_SIG);
      send_cen_body(CEN_FIXED, -1, 16'h0, 16'h0, 16'h0);
      settle();

      // local mode
      set_reg(CSR_HEADER_KIND, CSR_DATA_W'(KIND_LOCAL));
      push_byte(8'h50, 1'b1);
      send_noise(2);
      send_sig(1'b0, LOC_SIG);
      send_loc_body(LOC_FIXED, 8'hFF);
      send_noise(2);
      send_sig(1'b1, LOC_SIG);
      send_loc_body(LOC_FIXED, 8'h00);
      send_sig(1'b1, LOC_SIG);
      send_loc_body(10, -1);
      send_sig(1'b1, LOC_SIG);
      send_loc_body(LOC_FIXED, -1);
      settle();

      set_reg(CSR_HEADER_KIND, CSR_DATA_W'(KIND_CENTRAL));
      set_reg(CSR_RECORD_LIMIT, 16'($urandom_range(1, 8)));
      random_central(180);
      settle();
      set_reg(CSR_HEADER_KIND, CSR_DATA_W'(KIND_LOCAL));
      random_local(180);
      settle();

      tx_pct = 46;
      rx_pct = 21;
      set_reg(CSR_HEADER_KIND, CSR_DATA_W'(KIND_CENTRAL));
      set_reg(CSR_RECORD_LIMIT, 16'hFFFF);
      random_central(180);
      settle();
      set_reg(CSR_HEADER_KIND, CSR_DATA_W'(KIND_LOCAL));
      random_local(180);
      settle();

      tx_pct = 0;
      rx_pct = 0;
      set_reg(CSR_HEADER_KIND, CSR_DATA_W'(KIND_CENTRAL));
      set_reg(CSR_RECORD_LIMIT, 16'd1);
      random_central(180);
      settle();
      set_reg(CSR_RECORD_LIMIT, 16'($urandom_range(2, 12)));
      random_central(180);
      settle();

      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/zhp_pkg.sv
sv/zhp_front.sv
sv/zhp_queue.sv
sv/zhp_back.sv
sv/zip_header_field_parser.sv
dv/zip_header_checker.sv
dv/tb_zip_header_field_parser.sv
